/* hw/rtl/assert_macros.svh */
// assertion helpers, sampled on clk_i and switched off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define CPM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cpm assertion failed");

// expression must never be true out of reset
`define CPM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("cpm forbidden condition seen");

`endif

/* hw/rtl/cpm_pkg.sv */
package cpm_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SOURCE_BITS = 3;
  localparam int FACTOR_BITS = 8;
  localparam int CMD_BITS    = 2;
  localparam int CNT_BITS    = $clog2(TIME_BITS);

  localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(24);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_POLL  = 2'd0,
    CMD_PULSE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic                   start;
    logic [TIME_BITS-1:0]   dividend;
    logic [FACTOR_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TIME_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/cpm_if.sv */
interface cpm_in_if;
  logic                                valid;
  logic                                ready;
  logic [cpm_pkg::CMD_BITS-1:0]        command;
  logic [cpm_pkg::TIME_BITS-1:0]       now_us;
  logic [cpm_pkg::SOURCE_BITS-1:0]     in_source;
  logic                                in_physical;
  logic [cpm_pkg::TIME_BITS-1:0]       in_stamp_us;

  modport source (output valid, command, now_us, in_source, in_physical, in_stamp_us,
                  input ready);
  modport sink   (input valid, command, now_us, in_source, in_physical, in_stamp_us,
                  output ready);
endinterface

interface cpm_out_if;
  logic                                valid;
  logic                                ready;
  logic [cpm_pkg::SOURCE_BITS-1:0]     out_source;
  logic                                out_resync;
  logic                                out_physical;
  logic [cpm_pkg::TIME_BITS-1:0]       out_stamp_us;

  modport source (output valid, out_source, out_resync, out_physical, out_stamp_us,
                  input ready);
  modport sink   (input valid, out_source, out_resync, out_physical, out_stamp_us,
                  output ready);
endinterface

/* hw/rtl/cpm_div.sv */
module cpm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpm_pkg::div_req_t req_i,
  output cpm_pkg::div_rsp_t rsp_o
);

  localparam int TB = cpm_pkg::TIME_BITS;
  localparam int FB = cpm_pkg::FACTOR_BITS;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cpm_pkg::CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [FB-1:0]                 rem_q, rem_d;
  logic [FB-1:0]                 dvs_q, dvs_d;
  logic [TB-1:0]                 quo_q, quo_d;
  logic [FB:0]                   trial;
  logic                          fits;

  // one restoring step per cycle, quotient bits shift in where dividend bits leave
  assign trial = {rem_q, quo_q[TB-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cpm_pkg::CNT_BITS'(TB - 1);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? FB'(trial - {1'b0, dvs_q}) : trial[FB-1:0];
      quo_d = {quo_q[TB-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hw/rtl/clock_pulse_multiplier.sv */
// clock pulse multiplier: echoes each incoming pulse and interpolates factor-1 more
// a result is registered in the output register in the cycle after its transaction is accepted
// input flow: the input waits while the output register is full; beyond that, a pulse with a
// previous pulse holds it until the serial divider is done (one quotient bit per cycle)
// reset: rst_ni async active low, clears control and multiplier state but not the output payload
`include "assert_macros.svh"

module clock_pulse_multiplier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cpm_pkg::FACTOR_BITS-1:0]    cfg_wdata_i,
  cpm_in_if.sink                             in_i,
  cpm_out_if.source                          out_o
);

  localparam int TB = cpm_pkg::TIME_BITS;
  localparam int SB = cpm_pkg::SOURCE_BITS;
  localparam int FB = cpm_pkg::FACTOR_BITS;

  // configuration register
  logic [FB-1:0] factor_q;
  logic [FB-1:0] eff_f;

  // sequencer
  cpm_pkg::state_e state_q, state_d;
  cpm_pkg::cmd_e   cmd;

  // multiplier state
  logic [FB-1:0] pulse_count_q;
  logic [TB-1:0] interval_q;
  logic [TB-1:0] last_time_q;
  logic          last_valid_q;
  logic [TB-1:0] next_time_q;
  logic          next_valid_q;
  logic [SB-1:0] cur_source_q;

  // output register
  logic          out_valid_q;
  logic [SB-1:0] out_source_q;
  logic          out_resync_q;
  logic          out_physical_q;
  logic [TB-1:0] out_stamp_q;

  logic          in_rdy;
  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic [TB-1:0] poll_diff;
  logic          poll_hit;
  logic [TB-1:0] echo_stamp;
  logic [TB-1:0] pulse_diff;

  cpm_pkg::div_req_t div_req;
  cpm_pkg::div_rsp_t div_rsp;

  // a factor of zero behaves as one
  assign eff_f = (factor_q == '0) ? FB'(1) : factor_q;

  assign cmd     = cpm_pkg::cmd_e'(in_i.command);
  assign in_fire = in_i.valid & in_rdy;

  // the output register may be reloaded in the cycle its transaction leaves
  assign out_free = !out_valid_q || out_o.ready;

  // interpolated pulse is due when now minus the scheduled time is not negative
  assign poll_diff = in_i.now_us - next_time_q;
  assign poll_hit  = (pulse_count_q != '0) && (pulse_count_q < eff_f) && next_valid_q
                     && !poll_diff[TB-1];

  // an echo or a due interpolated pulse fills the output register
  assign out_load = in_fire && ((cmd == cpm_pkg::CMD_PULSE)
                                || (cmd == cpm_pkg::CMD_POLL && poll_hit));

  // a zero stamp on a pulse means take the current time
  assign echo_stamp = (in_i.in_stamp_us != '0) ? in_i.in_stamp_us : in_i.now_us;
  assign pulse_diff = in_i.now_us - last_time_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpm_pkg::ST_IDLE: begin
        if (in_fire && cmd == cpm_pkg::CMD_PULSE && last_valid_q) state_d = cpm_pkg::ST_DIV;
      end
      cpm_pkg::ST_DIV: begin
        if (div_rsp.done) state_d = cpm_pkg::ST_IDLE;
      end
      default: state_d = cpm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_rdy           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = pulse_diff;
    div_req.divisor  = eff_f;
    case (state_q)
      cpm_pkg::ST_IDLE: begin
        in_rdy        = out_free;
        div_req.start = in_fire && cmd == cpm_pkg::CMD_PULSE && last_valid_q;
      end
      cpm_pkg::ST_DIV: begin
        in_rdy = 1'b0;
      end
      default: in_rdy = 1'b0;
    endcase
  end

  cpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= cpm_pkg::FACTOR_RESET;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // multiplier state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_count_q <= '0;
      interval_q    <= '0;
      last_time_q   <= '0;
      last_valid_q  <= 1'b0;
      next_time_q   <= '0;
      next_valid_q  <= 1'b0;
      cur_source_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      // held until taken, refilled by a new result
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);

      if (state_q == cpm_pkg::ST_DIV && div_rsp.done) begin
        // new interval known: first interpolated pulse one interval after the pulse
        interval_q   <= div_rsp.quotient;
        next_time_q  <= (div_rsp.quotient != '0) ? last_time_q + div_rsp.quotient : '0;
        next_valid_q <= div_rsp.quotient != '0;
      end

      if (in_fire) begin
        case (cmd)
          cpm_pkg::CMD_CLEAR: begin
            pulse_count_q <= '0;
            interval_q    <= '0;
            last_time_q   <= '0;
            last_valid_q  <= 1'b0;
            next_time_q   <= '0;
            next_valid_q  <= 1'b0;
            cur_source_q  <= '0;
          end
          cpm_pkg::CMD_PULSE: begin
            cur_source_q  <= in_i.in_source;
            last_time_q   <= in_i.now_us;
            last_valid_q  <= 1'b1;
            pulse_count_q <= FB'(1);
            if (!last_valid_q) begin
              // no earlier pulse: keep the interval and schedule from it now
              next_time_q  <= (interval_q != '0) ? in_i.now_us + interval_q : '0;
              next_valid_q <= interval_q != '0;
            end
          end
          cpm_pkg::CMD_POLL: begin
            if (poll_hit) begin
              pulse_count_q <= pulse_count_q + 1'b1;
              next_time_q   <= next_time_q + interval_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // output payload, loaded with the result of the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd == cpm_pkg::CMD_PULSE) begin
      out_source_q   <= in_i.in_source;
      out_resync_q   <= !last_valid_q;
      out_physical_q <= in_i.in_physical;
      out_stamp_q    <= echo_stamp;
    end else if (in_fire && cmd == cpm_pkg::CMD_POLL && poll_hit) begin
      out_source_q   <= cur_source_q;
      out_resync_q   <= 1'b0;
      out_physical_q <= 1'b0;
      out_stamp_q    <= next_time_q;
    end
  end

  assign in_i.ready         = in_rdy;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_source   = out_source_q;
  assign out_o.out_resync   = out_resync_q;
  assign out_o.out_physical = out_physical_q;
  assign out_o.out_stamp_us = out_stamp_q;

  // the sequencer never takes a transaction while the divider works
  `CPM_NEVER(a_no_accept_in_div, state_q == cpm_pkg::ST_DIV && in_rdy)
  // divider finishes only while the sequencer waits for it
  `CPM_ASSERT(a_done_in_div, div_rsp.done |-> state_q == cpm_pkg::ST_DIV)
  // a scheduled pulse always has a nonzero spacing
  `CPM_ASSERT(a_sched_interval, next_valid_q |-> interval_q != '0)
  // a repeat pulse always starts a division
  `CPM_ASSERT(a_pulse_divides,
              (in_fire && cmd == cpm_pkg::CMD_PULSE && last_valid_q) |=>
              state_q == cpm_pkg::ST_DIV)

endmodule

/* bench/clock_pulse_multiplier_tb.sv */
`timescale 1ns / 1ps

module clock_pulse_multiplier_tb;

  // command code the block must ignore
  localparam logic [cpm_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  // cycles without any transaction before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // settling time after the last result, long enough for a divide to finish
  localparam int SETTLE_CYCLES = 40;

  localparam int TBITS = cpm_pkg::TIME_BITS;
  localparam int SBITS = cpm_pkg::SOURCE_BITS;
  localparam int FBITS = cpm_pkg::FACTOR_BITS;
  localparam int CBITS = cpm_pkg::CMD_BITS;

  typedef struct packed {
    logic [CBITS-1:0] command;
    logic [TBITS-1:0] now_us;
    logic [SBITS-1:0] source;
    logic             physical;
    logic [TBITS-1:0] stamp_us;
  } pulse_in_t;

  typedef struct packed {
    logic [SBITS-1:0] source;
    logic             resync;
    logic             physical;
    logic [TBITS-1:0] stamp_us;
  } pulse_out_t;

  // tracks the multiplier state and holds the pulses still owed by the block
  class pulse_scoreboard;
    logic [FBITS-1:0] factor;
    logic [FBITS-1:0] pulse_count;
    logic [TBITS-1:0] interval_us;
    logic [TBITS-1:0] last_us;
    logic [TBITS-1:0] next_us;
    logic             last_seen;
    logic             next_armed;
    logic [SBITS-1:0] source;
    pulse_out_t       expected_pulses[$];
    int               errors;
    int               n_accepted;
    int               n_echo;
    int               n_interp;

    function new();
      factor     = cpm_pkg::FACTOR_RESET;
      errors     = 0;
      n_accepted = 0;
      n_echo     = 0;
      n_interp   = 0;
      clear_state();
    endfunction

    function void clear_state();
      pulse_count = '0;
      interval_us = '0;
      last_us     = '0;
      last_seen   = 1'b0;
      next_us     = '0;
      next_armed  = 1'b0;
      source      = '0;
    endfunction

    // one transaction in, at most one pulse out
    function bit step_multiplier(input pulse_in_t tr, output pulse_out_t p);
      logic [FBITS-1:0] mult;
      logic [TBITS-1:0] elapsed;
      mult = (factor == '0) ? FBITS'(1) : factor;
      p = '0;
      case (tr.command)
        cpm_pkg::CMD_CLEAR: begin
          clear_state();
          return 1'b0;
        end
        cpm_pkg::CMD_PULSE: begin
          p.resync = !last_seen;
          source = tr.source;
          if (last_seen) begin
            elapsed = tr.now_us - last_us;
            interval_us = elapsed / mult;
          end
          last_us     = tr.now_us;
          last_seen   = 1'b1;
          p.source    = source;
          p.physical  = tr.physical;
          p.stamp_us  = (tr.stamp_us != '0) ? tr.stamp_us : tr.now_us;
          pulse_count = FBITS'(1);
          if (interval_us != '0) begin
            next_us    = last_us + interval_us;
            next_armed = 1'b1;
          end else begin
            next_us    = '0;
            next_armed = 1'b0;
          end
          return 1'b1;
        end
        cpm_pkg::CMD_POLL: begin
          if (pulse_count == '0 || pulse_count >= mult || !next_armed) return 1'b0;
          elapsed = tr.now_us - next_us;
          if (elapsed[TBITS-1]) return 1'b0;
          p.source    = source;
          p.stamp_us  = next_us;
          pulse_count = pulse_count + 1'b1;
          next_us     = next_us + interval_us;
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_transaction(input pulse_in_t tr);
      pulse_out_t p;
      n_accepted++;
      if (step_multiplier(tr, p)) begin
        expected_pulses.push_back(p);
        if (tr.command == cpm_pkg::CMD_PULSE) n_echo++;
        else n_interp++;
      end
    endfunction

    task report_mismatch(input string what, input logic [TBITS-1:0] want,
                         input logic [TBITS-1:0] got);
      errors++;
      if (errors <= 25)
        $display("mismatch: %s expected 0x%0h got 0x%0h at %0t", what, want, got, $time);
    endtask

    task check_pulse(input pulse_out_t got);
      pulse_out_t want;
      if (expected_pulses.size() == 0) begin
        report_mismatch("pulse with none outstanding", '0, got.stamp_us);
        return;
      end
      want = expected_pulses.pop_front();
      if (got.source !== want.source)
        report_mismatch("out_source", TBITS'(want.source), TBITS'(got.source));
      if (got.resync !== want.resync)
        report_mismatch("out_resync", TBITS'(want.resync), TBITS'(got.resync));
      if (got.physical !== want.physical)
        report_mismatch("out_physical", TBITS'(want.physical), TBITS'(got.physical));
      if (got.stamp_us !== want.stamp_us)
        report_mismatch("out_stamp_us", want.stamp_us, got.stamp_us);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [FBITS-1:0] cfg_wdata_i;

  cpm_in_if  in_if ();
  cpm_out_if out_if ();

  pulse_scoreboard pulse_sb = new();

  // idle percentages per side, set per phase; zero gives a stretch with no gaps
  int in_idle_pct;
  int out_idle_pct;
  int out_stall_left;
  int quiet_cycles;

  clock_pulse_multiplier u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side back-pressure: random bursts of stalls, changed on the falling edge
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_if.ready = 1'b0;
    end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
      out_stall_left = $urandom_range(1, 12) - 1;
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // result monitor: values sampled at the rising edge, before the block updates them
  always @(posedge clk_i) begin
    pulse_out_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.source   = out_if.out_source;
      got.resync   = out_if.out_resync;
      got.physical = out_if.out_physical;
      got.stamp_us = out_if.out_stamp_us;
      pulse_sb.check_pulse(got);
    end
  end

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("clock_pulse_multiplier_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction, with an optional idle burst in front of it
  task automatic drive_item(input logic [CBITS-1:0] command,
                            input logic [TBITS-1:0] now_us,
                            input logic [SBITS-1:0] source,
                            input logic physical,
                            input logic [TBITS-1:0] stamp_us);
    pulse_in_t tr;
    tr = '{command, now_us, source, physical, stamp_us};
    @(negedge clk_i);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_if.valid       = 1'b1;
    in_if.command     = tr.command;
    in_if.now_us      = tr.now_us;
    in_if.in_source   = tr.source;
    in_if.in_physical = tr.physical;
    in_if.in_stamp_us = tr.stamp_us;
    do @(posedge clk_i); while (!in_if.ready);
    pulse_sb.note_transaction(tr);
  endtask

  // drop valid, wait for every owed pulse, then let a divide or poll finish
  task automatic settle_block();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pulse_sb.expected_pulses.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // factor is only written with the block quiet
  task automatic load_factor(input logic [FBITS-1:0] value);
    settle_block();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pulse_sb.factor = value;
  endtask

  // mostly well-formed pulse trains: a pulse, polls walking time forward at about
  // the interpolation interval, the next pulse one period later; some noise mixed in
  task automatic run_phase(input int n_items, input int in_pct, input int out_pct);
    logic [TBITS-1:0] clock_us;
    logic [TBITS-1:0] due_pulse_us;
    logic [TBITS-1:0] period_us;
    logic [TBITS-1:0] interp_us;
    logic [TBITS-1:0] lag_us;
    logic [FBITS-1:0] mult;
    int               done_items;
    int               pick;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    mult = (pulse_sb.factor == '0) ? FBITS'(1) : pulse_sb.factor;
    clock_us     = $urandom();
    due_pulse_us = clock_us;
    interp_us    = '0;
    done_items   = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      lag_us = clock_us - due_pulse_us;
      if (pick < 3) begin
        // ignored command, not counted
        drive_item(CMD_UNUSED, $urandom(), SBITS'($urandom()), 1'($urandom()), $urandom());
      end else if (pick < 8) begin
        // noise: any command at any time
        drive_item(CBITS'($urandom_range(0, 2)), $urandom(), SBITS'($urandom()),
                   1'($urandom()), $urandom());
        done_items++;
      end else if (pick < 10) begin
        drive_item(cpm_pkg::CMD_CLEAR, clock_us, SBITS'($urandom()), 1'($urandom()),
                   $urandom());
        done_items++;
      end else if (!lag_us[TBITS-1]) begin
        case ($urandom_range(9))
          0:       period_us = '0;                       // repeated pulse, zero interval
          1:       period_us = $urandom_range(1, mult);  // interval of 0 or 1
          default: period_us = mult * $urandom_range(1, 12) + $urandom_range(0, mult - 1);
        endcase
        interp_us = period_us / mult;
        drive_item(cpm_pkg::CMD_PULSE, clock_us, SBITS'($urandom()), 1'($urandom()),
                   $urandom_range(1) ? TBITS'(0) : TBITS'($urandom()));
        due_pulse_us = clock_us + period_us;
        done_items++;
      end else begin
        clock_us = clock_us + $urandom_range(0, (interp_us == '0) ? 3 : 2 * interp_us);
        drive_item(cpm_pkg::CMD_POLL, clock_us, SBITS'($urandom()), 1'($urandom()),
                   $urandom());
        done_items++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_if.valid    = 1'b0;
    in_if.command  = cpm_pkg::CMD_POLL;
    in_if.now_us   = '0;
    in_if.in_source   = '0;
    in_if.in_physical = 1'b0;
    in_if.in_stamp_us = '0;
    out_if.ready   = 1'b1;
    out_stall_left = 0;
    quiet_cycles   = 0;
    in_idle_pct    = 20;
    out_idle_pct   = 20;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at the reset factor of 24
    drive_item(cpm_pkg::CMD_POLL, '0, '0, 1'b0, '0);                 // poll with nothing seen
    drive_item(cpm_pkg::CMD_PULSE, 32'hFFFF_FFF0, 3'd7, 1'b1, '0);   // first pulse, resync
    drive_item(cpm_pkg::CMD_POLL, 32'hFFFF_FFF8, 3'd0, 1'b0, '0);    // nothing scheduled
    drive_item(cpm_pkg::CMD_PULSE, 32'h0000_0020, 3'd0, 1'b0, 32'hFFFF_FFFF); // across the wrap
    drive_item(cpm_pkg::CMD_POLL, 32'h0000_0021, 3'd7, 1'b1, 32'hFFFF_FFFF);  // not yet due
    drive_item(cpm_pkg::CMD_POLL, 32'h0000_0022, 3'd0, 1'b0, '0);    // due exactly
    drive_item(cpm_pkg::CMD_POLL, 32'hA000_0030, 3'd0, 1'b0, '0);    // far ahead reads as not yet due
    drive_item(cpm_pkg::CMD_POLL, 32'h0000_0030, 3'd0, 1'b0, '0);
    drive_item(CMD_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF); // ignored
    drive_item(cpm_pkg::CMD_POLL, 32'h8000_0025, 3'd0, 1'b0, '0);    // largest non-negative gap
    drive_item(cpm_pkg::CMD_PULSE, 32'h8000_0025, 3'd3, 1'b1, 32'h0000_0001); // nonzero interval, stamp used as given
    drive_item(cpm_pkg::CMD_POLL, 32'h8000_0030, 3'd0, 1'b0, '0);
    drive_item(cpm_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 3'd7, 1'b1, 32'hFFFF_FFFF);
    drive_item(cpm_pkg::CMD_POLL, 32'h8000_0040, 3'd0, 1'b0, '0);    // cleared, nothing owed
    drive_item(cpm_pkg::CMD_PULSE, '0, 3'd5, 1'b0, '0);              // resync again, stamp of 0
    drive_item(cpm_pkg::CMD_PULSE, 32'h0000_0048, 3'd2, 1'b1, '0);   // interval of 3
    drive_item(cpm_pkg::CMD_POLL, 32'h0000_004B, 3'd0, 1'b0, '0);
    drive_item(cpm_pkg::CMD_POLL, 32'hFFFF_FFFF, 3'd0, 1'b0, '0);    // earlier than scheduled

    // random phases over several factor settings, extremes included
    load_factor(8'd24);
    run_phase(140, 20, 15);
    load_factor(8'd1);
    run_phase(120, 10, 30);
    load_factor(8'd255);
    run_phase(300, 0, 10);
    load_factor(8'd0);                 // zero behaves as one
    run_phase(100, 25, 25);
    load_factor(8'd2);
    run_phase(120, 15, 0);
    load_factor(FBITS'($urandom_range(3, 40)));
    run_phase(160, 30, 30);
    load_factor(FBITS'($urandom_range(41, 254)));
    run_phase(100, 10, 10);
    // closing stretch with both sides always willing
    load_factor(8'd7);
    run_phase(160, 0, 0);

    settle_block();
    $display("covered %0d transactions at factors 24, 1, 255, 0, 2, 7 and two random ones",
             pulse_sb.n_accepted);
    $display("checked %0d echoed and %0d interpolated pulses, %0d mismatches",
             pulse_sb.n_echo, pulse_sb.n_interp, pulse_sb.errors);
    if (pulse_sb.errors == 0 && pulse_sb.expected_pulses.size() == 0) begin
      $display("clock_pulse_multiplier_tb passed");
    end else begin
      $display("clock_pulse_multiplier_tb failed");
    end
    $finish;
  end

endmodule
